// File: src/pol_pkg.sv
// Package for the positional ordered list.
// Field widths, command and status codes. No dependencies.
package pol_pkg;

  localparam int CmdW = 3;
  localparam int PosW = 8;
  localparam int ValW = 32;
  localparam int StW  = 2;

  typedef logic [CmdW-1:0]        cmd_t;
  typedef logic [PosW-1:0]        pos_t;
  typedef logic signed [ValW-1:0] val_t;
  typedef logic [StW-1:0]         st_t;

  localparam cmd_t CMD_INS_HEAD = 3'd0;
  localparam cmd_t CMD_INS_TAIL = 3'd1;
  localparam cmd_t CMD_INS_POS  = 3'd2;
  localparam cmd_t CMD_DEL_POS  = 3'd3;
  localparam cmd_t CMD_READ_OUT = 3'd4;

  localparam st_t ST_OK     = 2'd0;
  localparam st_t ST_BADPOS = 2'd1;
  localparam st_t ST_FULL   = 2'd2;
  localparam st_t ST_EMPTY  = 2'd3;

endpackage

// File: src/pol_if.sv
// Valid/ready channels of the positional ordered list: command items in,
// result items out. Depends on pol_pkg.
interface pol_cmd_if;
  import pol_pkg::*;

  logic valid;
  logic ready;
  cmd_t command;
  pos_t position;
  val_t value;

  modport source (output valid, output command, output position, output value, input ready);
  modport sink   (input valid, input command, input position, input value, output ready);
endinterface

interface pol_res_if;
  import pol_pkg::*;

  logic valid;
  logic ready;
  st_t  status;
  val_t element;
  logic last;

  modport source (output valid, output status, output element, output last, input ready);
  modport sink   (input valid, input status, input element, input last, output ready);
endinterface

// File: src/positional_ordered_list.sv
// Positional ordered list. Insert shifts the cells at and above the index up by one, then
// writes the value; delete shifts the cells above it down. Bad position, full list, empty
// read: a status result only. Read out: one result per element while results are taken.
// One command item at a time; the next is taken once the sequencer is back to idle and
// the result register is free. Reset clears the count and result valid flag, not the cells.
module positional_ordered_list #(
  parameter int CAPACITY = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pol_cmd_if.sink   cmd_i,
  pol_res_if.source res_o
);
  import pol_pkg::*;

  localparam int AddrW = $clog2(CAPACITY);

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  val_t             ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  val_t             ram_rdata;

  pol_seq #(
    .Capacity (CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .res_o       (res_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  pol_ram #(
    .Width (ValW),
    .Depth (CAPACITY)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// File: src/pol_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pol_ram #(
  parameter int Width = 32,
  parameter int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/pol_seq.sv
// Sequencer of the positional ordered list: command decode, element count,
// cell shifting through the RAM by read and write states, result register.
// Depends on pol_pkg and pol_if.
module pol_seq #(
  parameter int Capacity = 32,
  localparam int AddrW = $clog2(Capacity),
  localparam int CntW  = $clog2(Capacity + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pol_cmd_if.sink               cmd_i,
  pol_res_if.source             res_o,
  output logic                  ram_we_o,
  output logic [AddrW-1:0]      ram_waddr_o,
  output pol_pkg::val_t         ram_wdata_o,
  output logic [AddrW-1:0]      ram_raddr_o,
  input  pol_pkg::val_t         ram_rdata_i
);
  import pol_pkg::*;

  localparam int PosExtW = PosW + 1;
  typedef logic [PosExtW-1:0] pos_ext_t;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SH_RD   = 3'd1;
  localparam logic [2:0] S_SH_WR   = 3'd2;
  localparam logic [2:0] S_WR_NEW  = 3'd3;
  localparam logic [2:0] S_DL_RD   = 3'd4;
  localparam logic [2:0] S_DL_WR   = 3'd5;
  localparam logic [2:0] S_RD_REQ  = 3'd6;
  localparam logic [2:0] S_RD_WAIT = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] pidx_q, pidx_d;
  val_t            value_q, value_d;
  logic            res_valid_q, res_valid_d;
  st_t             res_status_q, res_status_d;
  val_t            res_element_q, res_element_d;
  logic            res_last_q, res_last_d;

  logic            out_free;
  logic            cmd_fire;
  logic            list_full;
  logic            ins_ok;
  logic            del_ok;
  logic            rd_last;
  pos_ext_t        pos_ext;
  pos_ext_t        cnt_ext;
  logic [AddrW-1:0] pos_idx;
  logic            is_insert;

  assign out_free    = !res_valid_q || res_o.ready;
  assign cmd_i.ready = (state_q == S_IDLE) && out_free;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;

  assign list_full = (count_q == CntW'(Capacity));
  assign pos_ext   = pos_ext_t'(cmd_i.position);
  assign cnt_ext   = pos_ext_t'(count_q);
  assign ins_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext + pos_ext_t'(1));
  assign del_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign pos_idx   = AddrW'(cmd_i.position - pos_t'(1));
  assign rd_last   = (CntW'(idx_q) == count_q - CntW'(1));
  assign is_insert = (cmd_i.command == CMD_INS_HEAD) || (cmd_i.command == CMD_INS_TAIL) ||
                     (cmd_i.command == CMD_INS_POS);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    pidx_d        = pidx_q;
    value_d       = value_q;
    res_valid_d   = res_valid_q && !res_o.ready;
    res_status_d  = res_status_q;
    res_element_d = res_element_q;
    res_last_d    = res_last_q;
    ram_we_o      = 1'b0;
    ram_waddr_o   = idx_q;
    ram_wdata_o   = ram_rdata_i;
    ram_raddr_o   = idx_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_fire) begin
          res_element_d = '0;
          res_last_d    = 1'b1;
          case (cmd_i.command)
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
              if (list_full) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_FULL;
              end else if (cmd_i.command == CMD_INS_POS && !ins_ok) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_BADPOS;
              end else begin
                if (cmd_i.command == CMD_INS_HEAD) begin
                  pidx_d = '0;
                end else if (cmd_i.command == CMD_INS_TAIL) begin
                  pidx_d = AddrW'(count_q);
                end else begin
                  pidx_d = pos_idx;
                end
                idx_d   = AddrW'(count_q);
                value_d = cmd_i.value;
                state_d = S_SH_RD;
              end
            end
            CMD_DEL_POS: begin
              if (!del_ok) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_BADPOS;
              end else begin
                pidx_d  = pos_idx;
                idx_d   = pos_idx;
                state_d = S_DL_RD;
              end
            end
            CMD_READ_OUT: begin
              if (count_q == '0) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = S_RD_REQ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SH_RD: begin
        if (idx_q == pidx_q) begin
          state_d = S_WR_NEW;
        end else begin
          ram_raddr_o = idx_q - AddrW'(1);
          state_d     = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q;
        idx_d       = idx_q - AddrW'(1);
        state_d     = S_SH_RD;
      end
      S_WR_NEW: begin
        ram_we_o      = 1'b1;
        ram_waddr_o   = pidx_q;
        ram_wdata_o   = value_q;
        count_d       = count_q + CntW'(1);
        res_valid_d   = 1'b1;
        res_status_d  = ST_OK;
        res_element_d = '0;
        res_last_d    = 1'b1;
        state_d       = S_IDLE;
      end
      S_DL_RD: begin
        if (CntW'(idx_q) + CntW'(1) >= count_q) begin
          count_d       = count_q - CntW'(1);
          res_valid_d   = 1'b1;
          res_status_d  = ST_OK;
          res_element_d = '0;
          res_last_d    = 1'b1;
          state_d       = S_IDLE;
        end else begin
          ram_raddr_o = idx_q + AddrW'(1);
          state_d     = S_DL_WR;
        end
      end
      S_DL_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q;
        idx_d       = idx_q + AddrW'(1);
        state_d     = S_DL_RD;
      end
      S_RD_REQ: begin
        state_d = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        if (out_free) begin
          res_valid_d   = 1'b1;
          res_status_d  = ST_OK;
          res_element_d = ram_rdata_i;
          res_last_d    = rd_last;
          if (rd_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + AddrW'(1);
            state_d = S_RD_REQ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    pidx_q        <= pidx_d;
    value_q       <= value_d;
    res_status_q  <= res_status_d;
    res_element_q <= res_element_d;
    res_last_q    <= res_last_d;
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.status  = res_status_q;
  assign res_o.element = res_element_q;
  assign res_o.last    = res_last_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("element count above capacity");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ready |-> (state_q == S_IDLE))
    else $error("command taken while busy");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_fire && is_insert && list_full) |=> (res_valid_q && res_status_q == ST_FULL))
    else $error("insert into full list without full status");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CntW'(1) || count_q == $past(count_q) - CntW'(1)))
    else $error("element count changed by more than one");

endmodule

// File: tb/sv/positional_ordered_list_tb.sv
`timescale 1ns / 1ps
// Testbench for positional_ordered_list: directed, pressure and random command items,
// checked against an in-bench list model. Depends on pol_pkg, pol_if and the block's RTL.
module positional_ordered_list_tb;
  import pol_pkg::*;

  localparam int CAPACITY     = 32;
  localparam int RANDOM_ITEMS = 240;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT        = 2_000_000;

  typedef struct packed {
    st_t  status;
    val_t element;
    logic last;
  } list_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pol_cmd_if cmd_if ();
  pol_res_if res_if ();

  positional_ordered_list #(.CAPACITY(CAPACITY)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  val_t         list_cells [CAPACITY];
  int           list_count = 0;
  list_result_t expected_results [$];
  list_result_t oldest;
  int           mismatches = 0;
  int           cycle_count = 0;
  bit           tx_gaps = 1'b1;
  bit           rx_gaps = 1'b1;
  int           rx_hold_request = 0;
  int           rx_stall = 0;

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic val_t pick_value();
    case ($urandom_range(0, 11))
      0: return {1'b1, {31{1'b0}}};
      1: return {1'b0, {31{1'b1}}};
      2: return '0;
      3: return '1;
      default: return val_t'($urandom);
    endcase
  endfunction

  function automatic void push_status(st_t st);
    list_result_t r;
    r.status  = st;
    r.element = '0;
    r.last    = 1'b1;
    expected_results.push_back(r);
  endfunction

  // Update the list model with one accepted command and queue the results it causes.
  function automatic void apply_command(cmd_t c, pos_t p, val_t v);
    int idx;
    list_result_t r;
    case (c)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
        if (list_count >= CAPACITY) begin
          push_status(ST_FULL);
        end else if (c == CMD_INS_POS && (p == 0 || int'(p) > list_count + 1)) begin
          push_status(ST_BADPOS);
        end else begin
          if (c == CMD_INS_HEAD) idx = 0;
          else if (c == CMD_INS_TAIL) idx = list_count;
          else idx = int'(p) - 1;
          for (int i = list_count; i > idx; i--) list_cells[i] = list_cells[i-1];
          list_cells[idx] = v;
          list_count++;
          push_status(ST_OK);
        end
      end
      CMD_DEL_POS: begin
        if (p == 0 || int'(p) > list_count) begin
          push_status(ST_BADPOS);
        end else begin
          for (int i = int'(p) - 1; i + 1 < list_count; i++) list_cells[i] = list_cells[i+1];
          list_count--;
          push_status(ST_OK);
        end
      end
      CMD_READ_OUT: begin
        if (list_count == 0) begin
          push_status(ST_EMPTY);
        end else begin
          for (int i = 0; i < list_count; i++) begin
            r.status  = ST_OK;
            r.element = list_cells[i];
            r.last    = (i == list_count - 1);
            expected_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_item(cmd_t c, pos_t p, val_t v);
    int unsigned gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.command  <= c;
    cmd_if.position <= p;
    cmd_if.value    <= v;
    do @(posedge clk_i); while (!cmd_if.ready);
    apply_command(c, p, v);
  endtask

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_request > 0) begin
        rx_stall = rx_hold_request;
        rx_hold_request = 0;
      end else if (rx_stall == 0 && rx_gaps && $urandom_range(0, 99) < 25) begin
        rx_stall = pick_gap();
      end
      if (rx_stall > 0) begin
        res_if.ready <= 1'b0;
        rx_stall--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: status %0d, element %0d, last %0b",
               res_if.status, res_if.element, res_if.last);
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        check_field("status", 64'(oldest.status), 64'(res_if.status));
        check_field("element", 64'(oldest.element), 64'(res_if.element));
        check_field("last", 64'(oldest.last), 64'(res_if.last));
      end
    end
  end

  task automatic test_empty_list();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    send_item(CMD_READ_OUT, '0, '0);
    send_item(CMD_DEL_POS, 8'd1, '0);
    send_item(CMD_DEL_POS, 8'd0, '1);
    send_item(CMD_INS_POS, 8'd0, 32'sd5);
    send_item(CMD_INS_POS, 8'd2, 32'sd6);
    send_item(cmd_t'(5), 8'd1, 32'sd7);
    send_item(cmd_t'(6), 8'd255, '1);
    send_item(cmd_t'(7), 8'd0, '0);
  endtask

  task automatic test_each_operation();
    send_item(CMD_INS_HEAD, '0, {1'b0, {31{1'b1}}});
    send_item(CMD_INS_HEAD, '1, {1'b1, {31{1'b0}}});
    send_item(CMD_INS_TAIL, '0, '0);
    send_item(CMD_INS_TAIL, '0, '1);
    send_item(CMD_INS_POS, 8'd1, 32'sd11);
    send_item(CMD_INS_POS, pos_t'(list_count + 1), 32'sd22);
    send_item(CMD_INS_POS, 8'd3, 32'sd33);
    send_item(CMD_INS_POS, 8'd255, 32'sd44);
    send_item(CMD_READ_OUT, '0, '0);
    send_item(CMD_DEL_POS, 8'd255, '0);
    send_item(CMD_DEL_POS, pos_t'(list_count + 1), '0);
    send_item(CMD_DEL_POS, pos_t'(list_count), '0);
    send_item(CMD_DEL_POS, 8'd1, '0);
    send_item(CMD_DEL_POS, 8'd2, '0);
    send_item(CMD_READ_OUT, '0, '0);
  endtask

  // Hold the result side off while the list fills; the block must stall its input.
  task automatic test_full_list_pressure();
    tx_gaps = 1'b0;
    rx_gaps = 1'b1;
    rx_hold_request = HOLD_CYCLES;
    while (list_count < CAPACITY) send_item(CMD_INS_TAIL, '0, pick_value());
    send_item(CMD_INS_HEAD, '0, 32'sd1);
    send_item(CMD_INS_TAIL, '0, 32'sd2);
    send_item(CMD_INS_POS, 8'd1, 32'sd3);
    send_item(CMD_INS_POS, 8'd0, 32'sd4);
    send_item(CMD_READ_OUT, '0, '0);
    send_item(CMD_DEL_POS, pos_t'(CAPACITY), '0);
    send_item(CMD_DEL_POS, 8'd1, '0);
    send_item(CMD_INS_POS, pos_t'(list_count + 1), pick_value());
    send_item(CMD_INS_HEAD, '0, pick_value());
    send_item(CMD_READ_OUT, '0, '0);
  endtask

  task automatic test_random_ops();
    int   done;
    int   stretch_left;
    int   r;
    bit   grow;
    cmd_t c;
    pos_t p;
    val_t v;
    done = 0;
    stretch_left = 0;
    grow = 1'b0;
    while (done < RANDOM_ITEMS) begin
      if (stretch_left == 0) begin
        stretch_left = 50;
        tx_gaps = (done == 0) ? 1'b0 : 1'($urandom_range(0, 1));
        rx_gaps = (done == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      end
      if (list_count == CAPACITY && $urandom_range(0, 3) == 0) grow = 1'b0;
      if (list_count == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
      v = pick_value();
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_item(cmd_t'($urandom_range(5, 7)), pos_t'($urandom), v);
        continue;
      end
      r = $urandom_range(0, 99);
      if (r < 10) c = CMD_READ_OUT;
      else if (r < (grow ? 30 : 75)) c = CMD_DEL_POS;
      else c = cmd_t'($urandom_range(0, 2));
      if ($urandom_range(0, 99) < 15) p = pos_t'($urandom_range(0, 255));
      else if (c == CMD_DEL_POS) p = pos_t'($urandom_range(1, list_count > 0 ? list_count : 1));
      else p = pos_t'($urandom_range(1, list_count + 1));
      send_item(c, p, v);
      done++;
      stretch_left--;
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cmd_if.valid    = 1'b0;
    cmd_if.command  = '0;
    cmd_if.position = '0;
    cmd_if.value    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_each_operation();
    test_full_list_pressure();
    test_random_ops();
    cmd_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
